@@ rtl/bgc_pkg.sv @@
// bgc_pkg: shared types and constants for the button gesture classifier
// event codes, register indexes, register reset values and the register struct
// no dependencies
package bgc_pkg;

    // event codes reported on the result stream
    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_CLICK   = 3'd1,
        EV_DOUBLE  = 3'd2,
        EV_PRESSED = 3'd3,
        EV_HOLD    = 3'd4
    } t_event;

    // register indexes on the configuration port
    localparam logic [2:0] REG_CLICK_MIN  = 3'd0;
    localparam logic [2:0] REG_CLICK_MAX  = 3'd1;
    localparam logic [2:0] REG_DBL_WAIT   = 3'd2;
    localparam logic [2:0] REG_HOLD_MIN   = 3'd3;
    localparam logic [2:0] REG_HOLD_INT   = 3'd4;
    localparam logic [2:0] REG_PRESS_MIN  = 3'd5;
    localparam logic [2:0] REG_DBL_EN     = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TIME_W     = 32;

    // register reset values
    localparam logic [15:0] RST_CLICK_MIN = 16'd50;
    localparam logic [15:0] RST_CLICK_MAX = 16'd500;
    localparam logic [15:0] RST_DBL_WAIT  = 16'd300;
    localparam logic [15:0] RST_HOLD_MIN  = 16'd1000;
    localparam logic [15:0] RST_HOLD_INT  = 16'd200;
    localparam logic [15:0] RST_PRESS_MIN = 16'd500;

    // register file contents seen by the classifier
    typedef struct packed {
        logic [15:0] click_min;
        logic [15:0] click_max;
        logic [15:0] dbl_wait;
        logic [15:0] hold_min;
        logic [15:0] hold_int;
        logic [15:0] press_min;
        logic        dbl_en;
    } t_cfg;

endpackage

@@ rtl/button_gesture_classifier.sv @@
// button_gesture_classifier: top level of the button gesture classifier
// input register, result register and stream handshakes around bgc_core
// depends on bgc_pkg, bgc_cfg_regs, bgc_core
//
//   channel   | direction | width | contents
//   ----------+-----------+-------+---------------------------------------------
//   s stream  | in        | 40    | tdata: button_active[0], time_ms[32:1], zeros
//   m stream  | out       | 8     | tdata: event_code[2:0], zeros
//   cfg write | in        | 3+16  | register index, write data
//
// one sample per cycle unless results stall; via input register, result register
// each sample gives exactly one result beat, event code 0 when nothing happened
// a stalled result beat holds in the result register while one more sample waits
// in the input register; the classifier state advances as a sample moves forward
// reset is synchronous, active low, and restores register defaults and clears state
module button_gesture_classifier (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // sample stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [39:0]                    i_s_tdata,   // button_active, time_ms, pad
    // event stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [7:0]                     o_m_tdata,   // event_code, pad
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [bgc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bgc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bgc_pkg::*;

    t_cfg              cfg;
    t_event            ev;
    logic              adv;

    logic              r_in_valid;
    logic              r_in_level;
    logic [TIME_W-1:0] r_in_time;
    logic              r_out_valid;
    t_event            r_out_ev;

    bgc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bgc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (adv),
        .i_level (r_in_level),
        .i_time  (r_in_time),
        .o_event (ev)
    );

    // staged sample moves to the result register when that is free or drains
    assign adv        = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_level <= i_s_tdata[0];
            r_in_time  <= i_s_tdata[TIME_W:1];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_ev <= ev;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_ev};

endmodule

@@ rtl/bgc_cfg_regs.sv @@
// bgc_cfg_regs: configuration register file of the button gesture classifier
// plain write port, no read-back; indexes outside the list are ignored
// depends on bgc_pkg
module bgc_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bgc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bgc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output bgc_pkg::t_cfg                  o_cfg
);
    import bgc_pkg::*;

    t_cfg r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.click_min <= RST_CLICK_MIN;
            r_cfg.click_max <= RST_CLICK_MAX;
            r_cfg.dbl_wait  <= RST_DBL_WAIT;
            r_cfg.hold_min  <= RST_HOLD_MIN;
            r_cfg.hold_int  <= RST_HOLD_INT;
            r_cfg.press_min <= RST_PRESS_MIN;
            r_cfg.dbl_en    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CLICK_MIN: r_cfg.click_min <= i_cfg_data;
                REG_CLICK_MAX: r_cfg.click_max <= i_cfg_data;
                REG_DBL_WAIT:  r_cfg.dbl_wait  <= i_cfg_data;
                REG_HOLD_MIN:  r_cfg.hold_min  <= i_cfg_data;
                REG_HOLD_INT:  r_cfg.hold_int  <= i_cfg_data;
                REG_PRESS_MIN: r_cfg.press_min <= i_cfg_data;
                REG_DBL_EN:    r_cfg.dbl_en    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/bgc_core.sv @@
// bgc_core: gesture state and classification logic for one sample
// computes the event of the staged sample and updates state when it advances
// depends on bgc_pkg
module bgc_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bgc_pkg::t_cfg               i_cfg,
    input  logic                        i_step,
    input  logic                        i_level,
    input  logic [bgc_pkg::TIME_W-1:0]  i_time,
    output bgc_pkg::t_event             o_event
);
    import bgc_pkg::*;

    logic              r_prev_level, n_prev_level;
    logic [TIME_W-1:0] r_edge_time,  n_edge_time;
    logic              r_click_pend, n_click_pend;
    logic              r_press_mark, n_press_mark;
    logic [TIME_W-1:0] r_click_time, n_click_time;
    logic [TIME_W-1:0] r_hold_time,  n_hold_time;
    t_event            n_ev;

    logic [TIME_W-1:0] dur;
    logic [TIME_W-1:0] since_click;
    logic [TIME_W-1:0] since_hold;
    logic              is_click;
    logic              in_dbl_win;

    // elapsed times, all modulo 2^32
    assign dur         = i_time - r_edge_time;
    assign since_click = i_time - r_click_time;
    assign since_hold  = i_time - r_hold_time;
    assign is_click    = (dur > {16'd0, i_cfg.click_min}) && (dur < {16'd0, i_cfg.click_max});
    assign in_dbl_win  = since_click < {16'd0, i_cfg.dbl_wait};

    // classification and next state
    always_comb begin
        n_prev_level = r_prev_level;
        n_edge_time  = r_edge_time;
        n_click_pend = r_click_pend;
        n_press_mark = r_press_mark;
        n_click_time = r_click_time;
        n_hold_time  = r_hold_time;
        n_ev         = EV_NONE;
        if (i_level != r_prev_level) begin
            if (!i_level) begin
                // release edge
                if (is_click) begin
                    if (r_click_pend && in_dbl_win) begin
                        n_ev         = i_cfg.dbl_en ? EV_DOUBLE : EV_NONE;
                        n_click_pend = 1'b0;
                    end else if (!i_cfg.dbl_en) begin
                        n_ev = EV_CLICK;
                    end else begin
                        n_click_pend = 1'b1;
                        n_click_time = i_time;
                    end
                end else if (r_press_mark) begin
                    n_ev         = EV_PRESSED;
                    n_press_mark = 1'b0;
                end
            end else begin
                // press edge
                n_press_mark = 1'b0;
            end
            n_edge_time  = i_time;
            n_prev_level = i_level;
        end else if (i_level) begin
            // steady active level: hold repeats or press mark
            if (dur > {16'd0, i_cfg.hold_min}) begin
                n_press_mark = 1'b0;
                if (since_hold >= {16'd0, i_cfg.hold_int}) begin
                    n_ev        = EV_HOLD;
                    n_hold_time = i_time;
                end
            end else if (!r_press_mark && dur >= {16'd0, i_cfg.press_min}) begin
                n_press_mark = 1'b1;
            end
        end else begin
            // steady inactive level: release a deferred click
            if (r_click_pend && !in_dbl_win) begin
                n_ev         = EV_CLICK;
                n_click_pend = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= 1'b0;
            r_click_pend <= 1'b0;
            r_press_mark <= 1'b0;
            r_edge_time  <= '0;
            r_click_time <= '0;
            r_hold_time  <= '0;
        end else if (i_step) begin
            r_prev_level <= n_prev_level;
            r_click_pend <= n_click_pend;
            r_press_mark <= n_press_mark;
            r_edge_time  <= n_edge_time;
            r_click_time <= n_click_time;
            r_hold_time  <= n_hold_time;
        end
    end

    assign o_event = n_ev;

    // a click can only be deferred while double click detection is on
    a_defer_needs_dbl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !r_click_pend && n_click_pend) |-> i_cfg.dbl_en)
        else $error("click deferred with double click disabled");

    // hold comes only from a steady active level, which stays active
    a_hold_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && n_ev == EV_HOLD) |=> (r_prev_level && r_hold_time == $past(i_time)))
        else $error("hold event without active level");

    // a pressed event consumes the press mark
    a_pressed_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && n_ev == EV_PRESSED) |=> (!r_press_mark && !r_prev_level))
        else $error("press mark survived a pressed event");

    // state only moves when a sample advances
    a_state_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_edge_time) && $stable(r_click_pend) && $stable(r_press_mark)))
        else $error("state changed without a sample");

endmodule
